>>> rtl/sockp_pkg.sv
`default_nettype none

package sockp_pkg;

  typedef enum logic [3:0] {
    PhVer      = 4'd0,
    PhAuthNum  = 4'd1,
    PhAuth     = 4'd2,
    PhReqVer   = 4'd3,
    PhCmd      = 4'd4,
    PhRsv      = 4'd5,
    PhAtyp     = 4'd6,
    PhIpv4     = 4'd7,
    PhIpv6     = 4'd8,
    PhHostSize = 4'd9,
    PhHost5    = 4'd10,
    PhPort     = 4'd11,
    PhIdent    = 4'd12,
    PhHost4a   = 4'd13,
    PhDone     = 4'd14,
    PhDead     = 4'd15
  } phase_e;

  typedef enum logic [2:0] {
    EvConsumed = 3'd0,
    EvAddr     = 3'd1,
    EvAuth     = 3'd2,
    EvAccept   = 3'd3,
    EvFail     = 3'd4,
    EvTerm     = 3'd5,
    EvPayload  = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    RsnGeneral  = 2'd0,
    RsnCommand  = 2'd1,
    RsnAddress  = 2'd2,
    RsnHostLong = 2'd3
  } reason_e;

  localparam logic [2:0] Ver4 = 3'd4;
  localparam logic [2:0] Ver5 = 3'd5;

  localparam logic [1:0] CmdConnect = 2'd1;
  localparam logic [1:0] CmdBind    = 2'd2;
  localparam logic [1:0] CmdUdp     = 2'd3;

  localparam logic [2:0] AkIpv4   = 3'd1;
  localparam logic [2:0] AkDomain = 3'd3;
  localparam logic [2:0] AkIpv6   = 3'd4;

  localparam logic [7:0] HostMax    = 8'd255;
  localparam logic [7:0] Ipv6Bytes  = 8'd16;
  localparam logic [7:0] Ipv4Bytes  = 8'd4;
  localparam logic [7:0] PortBytes  = 8'd2;
  localparam logic [7:0] MethodNone = 8'd0;

  // ".i2p", entry 0 first
  localparam logic [3:0][7:0] Needle = {8'h70, 8'h32, 8'h69, 8'h2e};

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  ver;
    logic [1:0]  cmd;
    logic [2:0]  akind;
    logic [7:0]  left;
    logic [15:0] port;
    logic [31:0] ipv4;
    logic        s4a;
    logic [7:0]  hcount;
    logic [1:0]  prog;
    logic        found;
    logic        auth_none;
  } state_t;

  localparam state_t StateReset = '{
    phase:     PhVer,
    ver:       Ver5,
    cmd:       CmdConnect,
    akind:     AkIpv4,
    left:      8'd0,
    port:      16'd0,
    ipv4:      32'd0,
    s4a:       1'b0,
    hcount:    8'd0,
    prog:      2'd0,
    found:     1'b0,
    auth_none: 1'b0
  };

  typedef struct packed {
    event_e      ev;
    logic [7:0]  dout;
    reason_e     reason;
    logic [2:0]  version;
    logic [1:0]  cmd;
    logic [2:0]  akind;
    logic [15:0] port;
    logic [31:0] ipv4;
    logic [7:0]  hlen;
    logic [7:0]  auth;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sockp_step.sv
`default_nettype none

module sockp_step (
  input  sockp_pkg::state_t  state_i,
  input  logic               new_session_i,
  input  logic [7:0]         data_i,
  output sockp_pkg::state_t  state_o,
  output sockp_pkg::result_t result_o
);
  import sockp_pkg::*;

  state_t     cur;
  state_t     nxt;
  event_e     ev;
  reason_e    rsn;
  logic [7:0] dout;
  logic [7:0] left_dec;
  logic [1:0] prog_mt;
  logic       found_mt;
  logic [31:0] ipv4_sh;

  assign cur      = new_session_i ? StateReset : state_i;
  assign left_dec = cur.left - 8'd1;
  assign ipv4_sh  = {cur.ipv4[23:0], data_i};

  // ".i2p" matcher, restarts on a dot after a mismatch
  always_comb begin
    found_mt = cur.found;
    if (data_i == Needle[cur.prog]) begin
      if (cur.prog == 2'd3) begin
        found_mt = 1'b1;
        prog_mt  = 2'd0;
      end else begin
        prog_mt = cur.prog + 2'd1;
      end
    end else begin
      prog_mt = (data_i == Needle[0]) ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    nxt  = cur;
    ev   = EvConsumed;
    rsn  = RsnGeneral;
    dout = 8'd0;

    case (cur.phase)
      PhVer: begin
        if (data_i == 8'd4) begin
          nxt.ver   = Ver4;
          nxt.phase = PhCmd;
        end else if (data_i == 8'd5) begin
          nxt.ver   = Ver5;
          nxt.phase = PhAuthNum;
        end else begin
          nxt.ver   = 3'd0;
          nxt.phase = PhDead;
          ev        = EvTerm;
        end
      end
      PhAuthNum: begin
        nxt.left = data_i;
        if (data_i == 8'd0) begin
          nxt.phase = PhDead;
          ev        = EvFail;
        end else begin
          nxt.phase = PhAuth;
        end
      end
      PhAuth: begin
        nxt.left      = left_dec;
        nxt.auth_none = cur.auth_none | (data_i == MethodNone);
        if (left_dec == 8'd0) begin
          ev        = EvAuth;
          nxt.phase = nxt.auth_none ? PhReqVer : PhDead;
        end
      end
      PhReqVer: begin
        if (data_i != 8'd5) begin
          nxt.phase = PhDead;
          ev        = EvFail;
        end else begin
          nxt.phase = PhCmd;
        end
      end
      PhCmd: begin
        if (data_i == {6'd0, CmdConnect} || data_i == {6'd0, CmdBind} ||
            (data_i == {6'd0, CmdUdp} && cur.ver == Ver5)) begin
          nxt.cmd = data_i[1:0];
          if (cur.ver == Ver5) begin
            nxt.phase = PhRsv;
          end else begin
            nxt.left  = PortBytes;
            nxt.phase = PhPort;
          end
        end else begin
          nxt.phase = PhDead;
          ev        = EvFail;
        end
      end
      PhRsv: begin
        if (data_i != 8'd0) begin
          nxt.phase = PhDead;
          ev        = EvFail;
        end else begin
          nxt.phase = PhAtyp;
        end
      end
      PhAtyp: begin
        if (data_i == {5'd0, AkIpv4}) begin
          nxt.akind = AkIpv4;
          nxt.ipv4  = 32'd0;
          nxt.left  = Ipv4Bytes;
          nxt.phase = PhIpv4;
        end else if (data_i == {5'd0, AkIpv6}) begin
          nxt.akind = AkIpv6;
          nxt.left  = Ipv6Bytes;
          nxt.phase = PhIpv6;
        end else if (data_i == {5'd0, AkDomain}) begin
          nxt.phase = PhHostSize;
        end else begin
          nxt.phase = PhDead;
          ev        = EvFail;
        end
      end
      PhIpv4: begin
        nxt.ipv4 = ipv4_sh;
        nxt.left = left_dec;
        if (left_dec == 8'd0) begin
          if (cur.ver == Ver5) begin
            nxt.left  = PortBytes;
            nxt.phase = PhPort;
          end else begin
            // 0.0.0.x with x nonzero announces a hostname after the ident
            nxt.s4a   = (ipv4_sh[31:8] == 24'd0) && (ipv4_sh[7:0] != 8'd0);
            nxt.phase = PhIdent;
          end
        end
      end
      PhIpv6: begin
        ev       = EvAddr;
        dout     = data_i;
        nxt.left = left_dec;
        if (left_dec == 8'd0) begin
          nxt.left  = PortBytes;
          nxt.phase = PhPort;
        end
      end
      PhHostSize: begin
        nxt.akind  = AkDomain;
        nxt.hcount = 8'd0;
        nxt.prog   = 2'd0;
        nxt.found  = 1'b0;
        nxt.left   = data_i;
        if (data_i == 8'd0) begin
          nxt.left  = PortBytes;
          nxt.phase = PhPort;
        end else begin
          nxt.phase = PhHost5;
        end
      end
      PhHost5: begin
        if (cur.hcount >= HostMax) begin
          nxt.phase = PhDead;
          ev        = EvFail;
          rsn       = RsnHostLong;
        end else begin
          ev         = EvAddr;
          dout       = data_i;
          nxt.hcount = cur.hcount + 8'd1;
          nxt.prog   = prog_mt;
          nxt.found  = found_mt;
          nxt.left   = left_dec;
          if (left_dec == 8'd0) begin
            nxt.left  = PortBytes;
            nxt.phase = PhPort;
          end
        end
      end
      PhPort: begin
        nxt.port = {cur.port[7:0], data_i};
        nxt.left = left_dec;
        if (left_dec == 8'd0) begin
          if (cur.ver == Ver5) begin
            if (cur.cmd != CmdConnect) begin
              nxt.phase = PhDead;
              ev        = EvFail;
              rsn       = RsnCommand;
            end else if (cur.akind != AkDomain || !cur.found) begin
              nxt.phase = PhDead;
              ev        = EvFail;
              rsn       = RsnAddress;
            end else begin
              nxt.phase = PhDone;
              ev        = EvAccept;
            end
          end else begin
            nxt.akind = AkIpv4;
            nxt.ipv4  = 32'd0;
            nxt.left  = Ipv4Bytes;
            nxt.phase = PhIpv4;
          end
        end
      end
      PhIdent: begin
        if (data_i == 8'd0) begin
          if (!cur.s4a) begin
            // SOCKS4 never carries a domain, so only the command decides
            nxt.phase = PhDead;
            ev        = EvFail;
            rsn       = (cur.cmd != CmdConnect) ? RsnCommand : RsnAddress;
          end else begin
            nxt.akind  = AkDomain;
            nxt.hcount = 8'd0;
            nxt.prog   = 2'd0;
            nxt.found  = 1'b0;
            nxt.phase  = PhHost4a;
          end
        end
      end
      PhHost4a: begin
        if (data_i == 8'd0) begin
          if (cur.cmd != CmdConnect) begin
            nxt.phase = PhDead;
            ev        = EvFail;
            rsn       = RsnCommand;
          end else if (cur.akind != AkDomain || !cur.found) begin
            nxt.phase = PhDead;
            ev        = EvFail;
            rsn       = RsnAddress;
          end else begin
            nxt.phase = PhDone;
            ev        = EvAccept;
          end
        end else if (cur.hcount >= HostMax) begin
          nxt.phase = PhDead;
          ev        = EvFail;
          rsn       = RsnHostLong;
        end else begin
          ev         = EvAddr;
          dout       = data_i;
          nxt.hcount = cur.hcount + 8'd1;
          nxt.prog   = prog_mt;
          nxt.found  = found_mt;
        end
      end
      PhDone: begin
        ev   = EvPayload;
        dout = data_i;
      end
      default: begin
        nxt.phase = PhDead;
        ev        = EvTerm;
      end
    endcase
  end

  assign state_o = nxt;

  always_comb begin
    result_o.ev      = ev;
    result_o.dout    = dout;
    result_o.reason  = rsn;
    result_o.version = (nxt.phase == PhVer) ? 3'd0 : nxt.ver;
    result_o.cmd     = nxt.cmd;
    result_o.akind   = nxt.akind;
    result_o.port    = nxt.port;
    result_o.ipv4    = nxt.ipv4;
    result_o.hlen    = nxt.hcount;
    result_o.auth    = nxt.auth_none ? 8'd0 : 8'd255;
  end

endmodule

`default_nettype wire

>>> rtl/socks_request_parser.sv
// SOCKS4/4a/5 client request parser, one client byte per transfer.
//
// Input channel (in_valid_i/in_ready_o): new_session_i and data_byte_i.
// new_session_i set on a transfer clears all parse state before that byte
// is parsed. Output channel (out_valid_o/out_ready_i): exactly one result
// per input byte, carrying the event code, the passed byte, the failure
// reason and a snapshot of the parsed request fields.
//
// The parse state is updated and the result is registered at the edge
// that takes the byte. Throughput is one byte per cycle unless the
// receiver stalls; the single result register is the only buffer, so
// in_ready_o is high whenever the result register is empty or is drained
// in that cycle. A stalled receiver therefore stalls the sender one for
// one, and a held result keeps its value until transferred.
//
// Reset puts the parser in the await-version phase (version 5, CONNECT,
// IPv4 defaults) and empties the result register.
`default_nettype none

module socks_request_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        new_session_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  data_byte_out_o,
  output logic [1:0]  fail_reason_o,
  output logic [2:0]  version_o,
  output logic [1:0]  command_code_o,
  output logic [2:0]  address_kind_o,
  output logic [15:0] dest_port_o,
  output logic [31:0] ipv4_address_o,
  output logic [7:0]  host_length_o,
  output logic [7:0]  auth_method_o
);
  import sockp_pkg::*;

  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    take;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  sockp_step u_step (
    .state_i       (state_q),
    .new_session_i (new_session_i),
    .data_i        (data_byte_i),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        state_q <= state_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = res_q.ev;
  assign data_byte_out_o = res_q.dout;
  assign fail_reason_o   = res_q.reason;
  assign version_o       = res_q.version;
  assign command_code_o  = res_q.cmd;
  assign address_kind_o  = res_q.akind;
  assign dest_port_o     = res_q.port;
  assign ipv4_address_o  = res_q.ipv4;
  assign host_length_o   = res_q.hlen;
  assign auth_method_o   = res_q.auth;

endmodule

`default_nettype wire

>>> rtl/sockp_checker.sv
`default_nettype none

module sockp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  event_res_o,
  input logic [7:0]  data_byte_out_o,
  input logic [1:0]  fail_reason_o
);
  import sockp_pkg::*;

  // one result register: free or draining means room for the next byte
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not follow result register occupancy");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted byte produced no result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(event_res_o) && $stable(data_byte_out_o))
    else $error("stalled result changed");

  a_dout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EvAddr && event_res_o != EvPayload
      |-> data_byte_out_o == 8'd0)
    else $error("byte passed on a non-data event");

  a_reason_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EvFail |-> fail_reason_o == RsnGeneral)
    else $error("failure reason set without a failure");

endmodule

bind socks_request_parser sockp_checker u_sockp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .event_res_o     (event_res_o),
  .data_byte_out_o (data_byte_out_o),
  .fail_reason_o   (fail_reason_o)
);

`default_nettype wire

>>> tb/sv/socks_result_checker.sv
`default_nettype none

module socks_result_checker
  import sockp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        new_session_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  event_res_i,
  input  logic [7:0]  data_byte_out_i,
  input  logic [1:0]  fail_reason_i,
  input  logic [2:0]  version_i,
  input  logic [1:0]  command_code_i,
  input  logic [2:0]  address_kind_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] ipv4_address_i,
  input  logic [7:0]  host_length_i,
  input  logic [7:0]  auth_method_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] NoMethod = 8'hFF;
  localparam logic [2:0] VerNone  = 3'd0;

  // shadow of the parse state
  phase_e      st_phase;
  logic [2:0]  st_ver;
  logic [1:0]  st_cmd;
  logic [2:0]  st_akind;
  logic [7:0]  st_left;
  logic [15:0] st_port;
  logic [31:0] st_ipv4;
  logic [31:0] st_marker;
  logic [7:0]  st_hcount;
  logic [1:0]  st_prog;
  logic        st_found;
  logic        st_none_offered;

  event_e      step_ev;
  reason_e     step_reason;

  result_t     pending_results[$];
  result_t     want;
  int          bad;

  function automatic void clear_session();
    st_phase        = PhVer;
    st_ver          = Ver5;
    st_cmd          = CmdConnect;
    st_akind        = AkIpv4;
    st_left         = 8'd0;
    st_port         = 16'd0;
    st_ipv4         = 32'd0;
    st_marker       = 32'd0;
    st_hcount       = 8'd0;
    st_prog         = 2'd0;
    st_found        = 1'b0;
    st_none_offered = 1'b0;
  endfunction

  function automatic void fail_session(input reason_e r);
    st_phase    = PhDead;
    step_ev     = EvFail;
    step_reason = r;
  endfunction

  function automatic void begin_host();
    st_akind  = AkDomain;
    st_hcount = 8'd0;
    st_prog   = 2'd0;
    st_found  = 1'b0;
  endfunction

  function automatic void start_ipv4();
    st_akind = AkIpv4;
    st_ipv4  = 32'd0;
    st_left  = Ipv4Bytes;
    st_phase = PhIpv4;
  endfunction

  // running match for ".i2p"; a mismatching '.' restarts at one
  function automatic void take_suffix_char(input logic [7:0] b);
    if (b == Needle[st_prog]) begin
      if (st_prog == 2'd3) begin
        st_found = 1'b1;
        st_prog  = 2'd0;
      end else begin
        st_prog = st_prog + 2'd1;
      end
    end else begin
      st_prog = (b == Needle[0]) ? 2'd1 : 2'd0;
    end
  endfunction

  function automatic void close_request();
    if (st_cmd != CmdConnect) begin
      fail_session(RsnCommand);
    end else if (st_akind != AkDomain || !st_found) begin
      fail_session(RsnAddress);
    end else begin
      st_phase = PhDone;
      step_ev  = EvAccept;
    end
  endfunction

  function automatic result_t parse_byte(input logic fresh, input logic [7:0] b);
    result_t    r;
    logic [7:0] pass;
    pass = 8'd0;
    if (fresh) clear_session();
    step_ev     = EvConsumed;
    step_reason = RsnGeneral;
    case (st_phase)
      PhVer: begin
        if (b == 8'(Ver4)) begin
          st_ver   = Ver4;
          st_phase = PhCmd;
        end else if (b == 8'(Ver5)) begin
          st_ver   = Ver5;
          st_phase = PhAuthNum;
        end else begin
          st_ver   = VerNone;
          st_phase = PhDead;
          step_ev  = EvTerm;
        end
      end
      PhAuthNum: begin
        st_left = b;
        if (b == 8'd0) fail_session(RsnGeneral);
        else st_phase = PhAuth;
      end
      PhAuth: begin
        st_left = st_left - 8'd1;
        if (b == MethodNone) st_none_offered = 1'b1;
        if (st_left == 8'd0) begin
          step_ev  = EvAuth;
          st_phase = st_none_offered ? PhReqVer : PhDead;
        end
      end
      PhReqVer: begin
        if (b != 8'(Ver5)) fail_session(RsnGeneral);
        else st_phase = PhCmd;
      end
      PhCmd: begin
        if (b == 8'(CmdConnect) || b == 8'(CmdBind) ||
            (b == 8'(CmdUdp) && st_ver == Ver5)) begin
          st_cmd = b[1:0];
          if (st_ver == Ver5) begin
            st_phase = PhRsv;
          end else begin
            st_left  = PortBytes;
            st_phase = PhPort;
          end
        end else begin
          fail_session(RsnGeneral);
        end
      end
      PhRsv: begin
        if (b != 8'd0) fail_session(RsnGeneral);
        else st_phase = PhAtyp;
      end
      PhAtyp: begin
        if (b == 8'(AkIpv4)) begin
          start_ipv4();
        end else if (b == 8'(AkIpv6)) begin
          st_akind = AkIpv6;
          st_left  = Ipv6Bytes;
          st_phase = PhIpv6;
        end else if (b == 8'(AkDomain)) begin
          st_phase = PhHostSize;
        end else begin
          fail_session(RsnGeneral);
        end
      end
      PhIpv4: begin
        st_ipv4 = {st_ipv4[23:0], b};
        st_left = st_left - 8'd1;
        if (st_left == 8'd0) begin
          if (st_ver == Ver5) begin
            st_left  = PortBytes;
            st_phase = PhPort;
          end else begin
            st_marker = st_ipv4;
            st_phase  = PhIdent;
          end
        end
      end
      PhIpv6: begin
        step_ev = EvAddr;
        pass    = b;
        st_left = st_left - 8'd1;
        if (st_left == 8'd0) begin
          st_left  = PortBytes;
          st_phase = PhPort;
        end
      end
      PhHostSize: begin
        begin_host();
        st_left = b;
        if (b == 8'd0) begin
          st_left  = PortBytes;
          st_phase = PhPort;
        end else begin
          st_phase = PhHost5;
        end
      end
      PhHost5: begin
        if (st_hcount >= HostMax) begin
          fail_session(RsnHostLong);
        end else begin
          step_ev   = EvAddr;
          pass      = b;
          st_hcount = st_hcount + 8'd1;
          take_suffix_char(b);
          st_left   = st_left - 8'd1;
          if (st_left == 8'd0) begin
            st_left  = PortBytes;
            st_phase = PhPort;
          end
        end
      end
      PhPort: begin
        st_port = {st_port[7:0], b};
        st_left = st_left - 8'd1;
        if (st_left == 8'd0) begin
          if (st_ver == Ver5) close_request();
          else start_ipv4();
        end
      end
      PhIdent: begin
        if (b == 8'd0) begin
          // 0.0.0.x with x nonzero announces a hostname
          if (st_marker == 32'd0 || st_marker > 32'd255) begin
            close_request();
          end else begin
            begin_host();
            st_phase = PhHost4a;
          end
        end
      end
      PhHost4a: begin
        if (b == 8'd0) begin
          close_request();
        end else if (st_hcount >= HostMax) begin
          fail_session(RsnHostLong);
        end else begin
          step_ev   = EvAddr;
          pass      = b;
          st_hcount = st_hcount + 8'd1;
          take_suffix_char(b);
        end
      end
      PhDone: begin
        step_ev = EvPayload;
        pass    = b;
      end
      default: begin
        st_phase = PhDead;
        step_ev  = EvTerm;
      end
    endcase
    r.ev      = step_ev;
    r.dout    = pass;
    r.reason  = step_reason;
    r.version = (st_phase == PhVer) ? VerNone : st_ver;
    r.cmd     = st_cmd;
    r.akind   = st_akind;
    r.port    = st_port;
    r.ipv4    = st_ipv4;
    r.hlen    = st_hcount;
    r.auth    = st_none_offered ? MethodNone : NoMethod;
    return r;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v,
               act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_session();
      pending_results.delete();
    end else begin
      // the result leaving now was predicted at an earlier transfer
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0d byte 0x%0h",
                   $time, event_res_i, data_byte_out_i);
          errors_o <= errors_o + 1;
        end else begin
          want = pending_results.pop_front();
          bad  = field_diff("event", want.ev, event_res_i)
               + field_diff("data_byte_out", want.dout, data_byte_out_i)
               + field_diff("fail_reason", want.reason, fail_reason_i)
               + field_diff("version", want.version, version_i)
               + field_diff("command_code", want.cmd, command_code_i)
               + field_diff("address_kind", want.akind, address_kind_i)
               + field_diff("dest_port", want.port, dest_port_i)
               + field_diff("ipv4_address", want.ipv4, ipv4_address_i)
               + field_diff("host_length", want.hlen, host_length_i)
               + field_diff("auth_method", want.auth, auth_method_i);
          if (bad != 0) errors_o <= errors_o + 1;
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(parse_byte(new_session_i, data_byte_i));
      end
    end
    pending_o <= pending_results.size();
  end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sockp_pkg::*;

  localparam int RandomBytes = 350;

  typedef struct packed {
    logic       fresh;
    logic [7:0] b;
  } client_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        new_session = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  ev_res;
  logic [7:0]  byte_out;
  logic [1:0]  reason;
  logic [2:0]  version;
  logic [1:0]  cmd_code;
  logic [2:0]  addr_kind;
  logic [15:0] port;
  logic [31:0] ipv4;
  logic [7:0]  host_len;
  logic [7:0]  auth;

  int           errors;
  int           pending;
  int           bytes_sent;
  int           random_start;
  bit           idle_on = 1'b1;
  client_byte_t client_q[$];

  socks_request_parser u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .new_session_i  (new_session),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .event_res_o    (ev_res),
    .data_byte_out_o(byte_out),
    .fail_reason_o  (reason),
    .version_o      (version),
    .command_code_o (cmd_code),
    .address_kind_o (addr_kind),
    .dest_port_o    (port),
    .ipv4_address_o (ipv4),
    .host_length_o  (host_len),
    .auth_method_o  (auth)
  );

  socks_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .new_session_i  (new_session),
    .data_byte_i    (data_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .event_res_i    (ev_res),
    .data_byte_out_i(byte_out),
    .fail_reason_i  (reason),
    .version_i      (version),
    .command_code_i (cmd_code),
    .address_kind_i (addr_kind),
    .dest_port_i    (port),
    .ipv4_address_i (ipv4),
    .host_length_i  (host_len),
    .auth_method_i  (auth),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("socks_request_parser test failed");
    $finish;
  end

  // result side: random stall before each transfer while idle_on is set
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic void add(input logic fresh, input logic [7:0] b);
    client_q.push_back('{fresh: fresh, b: b});
  endfunction

  function automatic logic [7:0] mostly(input logic [7:0] usual);
    return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : usual;
  endfunction

  task automatic send_one(input client_byte_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    new_session <= it.fresh;
    data_byte   <= it.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_all();
    while (client_q.size() > 0) begin
      send_one(client_q.pop_front());
      bytes_sent++;
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  // hostname text, often with ".i2p" planted somewhere
  function automatic void add_host(input int len, input bit no_nul);
    int         k;
    int         at;
    logic [7:0] c;
    at = (len >= 4 && $urandom_range(0, 2) != 0) ? $urandom_range(0, len - 4) : -1;
    for (k = 0; k < len; k++) begin
      if (at >= 0 && k >= at && k < at + 4) begin
        c = Needle[k - at];
      end else begin
        case ($urandom_range(0, 3))
          0:       c = Needle[$urandom_range(0, 3)];
          1:       c = 8'($urandom_range(8'h61, 8'h7a));
          default: c = 8'($urandom_range(0, 255));
        endcase
      end
      if (no_nul && c == 8'd0) c = 8'h2d;
      add(1'b0, c);
    end
  endfunction

  function automatic void add_tail();
    int k;
    for (k = $urandom_range(0, 4); k > 0; k--) add(1'b0, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_socks5();
    int         n;
    int         k;
    bit         offer;
    logic [7:0] atyp;
    add(1'b1, 8'(Ver5));
    case ($urandom_range(0, 29))
      0:       n = 0;
      1:       n = $urandom_range(5, 255);
      default: n = $urandom_range(1, 4);
    endcase
    add(1'b0, 8'(n));
    offer = $urandom_range(0, 4) != 0;
    for (k = 0; k < n; k++) begin
      if (offer && k == n - 1) add(1'b0, MethodNone);
      else add(1'b0, 8'($urandom_range(1, 255)));
    end
    add(1'b0, mostly(8'(Ver5)));
    case ($urandom_range(0, 9))
      0:       add(1'b0, 8'(CmdBind));
      1:       add(1'b0, 8'(CmdUdp));
      2:       add(1'b0, 8'($urandom_range(0, 255)));
      default: add(1'b0, 8'(CmdConnect));
    endcase
    add(1'b0, mostly(8'd0));
    case ($urandom_range(0, 9))
      0, 1:    atyp = 8'(AkIpv4);
      2:       atyp = 8'(AkIpv6);
      3:       atyp = 8'($urandom_range(0, 255));
      default: atyp = 8'(AkDomain);
    endcase
    add(1'b0, atyp);
    if (atyp == 8'(AkIpv4)) begin
      for (k = 0; k < 4; k++) add(1'b0, 8'($urandom_range(0, 255)));
    end else if (atyp == 8'(AkIpv6)) begin
      for (k = 0; k < 16; k++) add(1'b0, 8'($urandom_range(0, 255)));
    end else if (atyp == 8'(AkDomain)) begin
      case ($urandom_range(0, 29))
        0:       n = 0;
        1:       n = $urandom_range(25, 80);
        default: n = $urandom_range(1, 24);
      endcase
      add(1'b0, 8'(n));
      add_host(n, 1'b0);
    end
    add(1'b0, 8'($urandom_range(0, 255)));
    add(1'b0, 8'($urandom_range(0, 255)));
    add_tail();
  endfunction

  // host_bytes < 0: random request; otherwise a 4a CONNECT with that many host bytes
  function automatic void build_socks4(input int host_bytes);
    int          k;
    logic [31:0] addr;
    add(1'b1, 8'(Ver4));
    if (host_bytes >= 0) begin
      add(1'b0, 8'(CmdConnect));
    end else begin
      case ($urandom_range(0, 9))
        0:       add(1'b0, 8'(CmdBind));
        1:       add(1'b0, 8'(CmdUdp));
        2:       add(1'b0, 8'($urandom_range(0, 255)));
        default: add(1'b0, 8'(CmdConnect));
      endcase
    end
    add(1'b0, 8'($urandom_range(0, 255)));
    add(1'b0, 8'($urandom_range(0, 255)));
    case (host_bytes >= 0 ? 0 : $urandom_range(0, 3))
      0, 1:    addr = 32'($urandom_range(1, 255));
      2:       addr = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
      default: addr = {16'd0, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
    endcase
    for (k = 3; k >= 0; k--) add(1'b0, addr[k*8 +: 8]);
    for (k = $urandom_range(0, 4); k > 0; k--) add(1'b0, 8'($urandom_range(1, 255)));
    add(1'b0, 8'd0);
    add_host(host_bytes >= 0 ? host_bytes : $urandom_range(0, 24), 1'b1);
    add(1'b0, 8'd0);
    add_tail();
  endfunction

  initial begin
    int k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad version then a dead byte, zero method count,
    // no acceptable method, accepted CONNECT with payload, UDP under SOCKS4
    add(1'b1, 8'hFF);
    add(1'b0, 8'h00);
    add(1'b1, 8'(Ver5));
    add(1'b0, 8'd0);
    add(1'b1, 8'(Ver5));
    add(1'b0, 8'd1);
    add(1'b0, 8'hFF);
    add(1'b1, 8'(Ver5));
    add(1'b0, 8'd1);
    add(1'b0, MethodNone);
    add(1'b0, 8'(Ver5));
    add(1'b0, 8'(CmdConnect));
    add(1'b0, 8'd0);
    add(1'b0, 8'(AkDomain));
    add(1'b0, 8'd5);
    add(1'b0, 8'h61);
    for (k = 0; k < 4; k++) add(1'b0, Needle[k]);
    add(1'b0, 8'hFF);
    add(1'b0, 8'hFF);
    add(1'b0, 8'h80);
    add(1'b1, 8'(Ver4));
    add(1'b0, 8'(CmdUdp));
    send_all();
    drain();

    // longest SOCKS5 hostname, then a 4a hostname that runs one byte past the limit
    idle_on = 1'b0;
    add(1'b1, 8'(Ver5));
    add(1'b0, 8'd1);
    add(1'b0, MethodNone);
    add(1'b0, 8'(Ver5));
    add(1'b0, 8'(CmdConnect));
    add(1'b0, 8'd0);
    add(1'b0, 8'(AkDomain));
    add(1'b0, HostMax);
    add_host(int'(HostMax), 1'b0);
    add(1'b0, 8'h00);
    add(1'b0, 8'h50);
    build_socks4(int'(HostMax) + 1);
    send_all();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomBytes) begin
      idle_on = $urandom_range(0, 2) != 0;
      while (client_q.size() < 100) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: build_socks5();
          5, 6, 7:       build_socks4(-1);
          default: begin
            add(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            for (k = $urandom_range(0, 5); k > 0; k--) begin
              add(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
          end
        endcase
      end
      send_all();
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("socks_request_parser test passed");
    end else begin
      $display("socks_request_parser test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/sockp_pkg.sv
rtl/sockp_step.sv
rtl/socks_request_parser.sv
rtl/sockp_checker.sv
tb/sv/socks_result_checker.sv
tb/sv/tb.sv
